/* sv/button_press_volume_tone_selector_unit_defines.svh */
// Assertion macros shared by the button press selector checker
`ifndef BUTTON_PRESS_VOLUME_TONE_SELECTOR_UNIT_DEFINES_SVH
`define BUTTON_PRESS_VOLUME_TONE_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define BPVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpvt check failed");

// Next-cycle implication, disabled while reset is held
`define BPVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpvt check failed");

`endif

/* sv/bpvt_pkg.sv */
// Types, constants and lookup tables of the button press selector
package bpvt_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int TICKS_W     = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // Register indexes of the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 8'd1;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [TICKS_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [1:0]         STEP_RESET       = 2'd2;

    // Press phase codes
    localparam logic [1:0] PH_IDLE         = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE     = 2'd1;
    localparam logic [1:0] PH_HELD         = 2'd2;
    localparam logic [1:0] PH_WAIT_RELEASE = 2'd3;

    typedef struct packed {
        logic [TICKS_W-1:0] debounce_ticks;
        logic [TICKS_W-1:0] long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic       volume_write;
        logic       mute_off;
        logic       mute_on;
        logic       tone_changed;
        logic       tone_mode_led;
        logic [7:0] samples_per_period;
        logic [1:0] tone_step;
        logic [1:0] volume_step;
        logic [7:0] volume_level;
    } t_result;

    // Codec volume by volume index
    function automatic logic [7:0] vol_level(input logic [1:0] idx);
        logic [7:0] lvl;
        case (idx)
            2'd0:    lvl = 8'd0;
            2'd1:    lvl = 8'd128;
            2'd2:    lvl = 8'd192;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

    // Samples per tone period by tone index
    function automatic logic [7:0] tone_samples(input logic [1:0] idx);
        logic [7:0] spp;
        case (idx)
            2'd0:    spp = 8'd192;
            2'd1:    spp = 8'd96;
            2'd2:    spp = 8'd48;
            default: spp = 8'd24;
        endcase
        return spp;
    endfunction

endpackage

/* sv/bpvt_cfg_regs.sv */
// Configuration registers for debounce and long-press lengths
module bpvt_cfg_regs
    import bpvt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [CFG_INDEX_W-1:0] i_index,
    input  logic [TICKS_W-1:0]     i_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index; unknown indexes leave everything alone
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_DEBOUNCE:   n_cfg.debounce_ticks   = i_data;
                CFG_LONG_PRESS: n_cfg.long_press_ticks = i_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_RESET;
            r_cfg.long_press_ticks <= LONG_PRESS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/bpvt_press_fsm.sv */
// Debounce and press classification with volume and tone selection state
module bpvt_press_fsm
    import bpvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_tick,
    input  logic    i_pressed,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [1:0]         r_phase,     n_phase;
    logic [TICKS_W-1:0] r_delay,     n_delay;
    logic               r_tone_mode, n_tone_mode;
    logic [1:0]         r_vol_idx,   n_vol_idx;
    logic [1:0]         r_tone_idx,  n_tone_idx;
    logic               n_tone_chg, n_mute_on, n_mute_off, n_write;
    logic [TICKS_W-1:0] w_delay;
    logic               w_delay_zero;

    // Count the settling or hold delay down on a tick
    assign w_delay      = (i_tick && (r_delay != '0)) ? r_delay - 1'b1 : r_delay;
    assign w_delay_zero = (w_delay == '0);

    always_comb begin
        n_phase     = r_phase;
        n_delay     = w_delay;
        n_tone_mode = r_tone_mode;
        n_vol_idx   = r_vol_idx;
        n_tone_idx  = r_tone_idx;
        n_tone_chg  = 1'b0;
        n_mute_on   = 1'b0;
        n_mute_off  = 1'b0;
        n_write     = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_delay_zero && i_pressed) begin
                    n_delay = i_cfg.debounce_ticks;
                    n_phase = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (w_delay_zero && i_pressed) begin
                    n_delay = i_cfg.long_press_ticks;
                    n_phase = PH_HELD;
                end
            end
            PH_HELD: begin
                if (!w_delay_zero && !i_pressed) begin
                    // Short press: step tone or volume
                    if (r_tone_mode) begin
                        n_tone_idx = r_tone_idx + 2'd1;
                        n_tone_chg = 1'b1;
                        if (r_vol_idx == 2'd0) begin
                            n_vol_idx  = 2'd1;
                            n_write    = 1'b1;
                            n_mute_off = 1'b1;
                        end
                    end else begin
                        n_vol_idx = r_vol_idx + 2'd1;
                        if (n_vol_idx == 2'd0) begin
                            n_mute_on = 1'b1;
                        end else begin
                            n_write    = 1'b1;
                            n_mute_off = (r_vol_idx == 2'd0);
                        end
                    end
                    n_delay = i_cfg.debounce_ticks;
                    n_phase = PH_IDLE;
                end else if (w_delay_zero && i_pressed) begin
                    // Long press: toggle mode
                    n_tone_mode = ~r_tone_mode;
                    n_phase     = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!i_pressed) begin
                    n_delay = i_cfg.debounce_ticks;
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Advance state only when a request moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_delay     <= '0;
            r_tone_mode <= 1'b0;
            r_vol_idx   <= STEP_RESET;
            r_tone_idx  <= STEP_RESET;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_delay     <= n_delay;
            r_tone_mode <= n_tone_mode;
            r_vol_idx   <= n_vol_idx;
            r_tone_idx  <= n_tone_idx;
        end
    end

    // Result of the current request
    always_comb begin
        o_res.volume_level       = vol_level(n_vol_idx);
        o_res.volume_step        = n_vol_idx;
        o_res.tone_step          = n_tone_idx;
        o_res.samples_per_period = tone_samples(n_tone_idx);
        o_res.tone_mode_led      = n_tone_mode;
        o_res.tone_changed       = n_tone_chg;
        o_res.mute_on            = n_mute_on;
        o_res.mute_off           = n_mute_off;
        o_res.volume_write       = n_write;
    end

endmodule

/* sv/button_press_volume_tone_selector_unit.sv */
// Top level: button poll stream in, volume and tone selection stream out
// A poll request is captured in the input register and its result then in the result register.
// Throughput: one poll per cycle unless stalled; a single pass from input to result register.
// The output register holds a stalled result while the next poll waits in the input register.
// Reset (synchronous, active low) empties both registers, sets the phase to idle, the delay to 0,
// volume mode, volume and tone index 2, debounce 50 and long press 1000 ticks.
module button_press_volume_tone_selector_unit
    import bpvt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: [0] tick, [1] pressed, [7:2] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: [7:0] volume_level, [9:8] volume_step, [11:10] tone_step,
    // [19:12] samples_per_period, [20] tone_mode_led, [21] tone_changed,
    // [22] mute_on, [23] mute_off, [24] volume_write, [31:25] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [TICKS_W-1:0]     i_cfg_data
);

    localparam int RES_W = $bits(t_result);

    logic                   r_in_valid;
    logic                   r_in_tick;
    logic                   r_in_pressed;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic                   w_advance;
    logic                   w_step;
    t_cfg                   w_cfg;
    t_result                w_res;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_tick    <= s_axis_tdata[0];
            r_in_pressed <= s_axis_tdata[1];
        end
    end

    bpvt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    bpvt_press_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_tick    (r_in_tick),
        .i_pressed (r_in_pressed),
        .i_cfg     (w_cfg),
        .o_res     (w_res)
    );

    // Result register: hold while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_tdata <= {{(OUT_TDATA_W-RES_W){1'b0}}, w_res};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule

/* sv/bpvt_checker.sv */
// Port-level checks of the button press selector, bound to the top level
`include "button_press_volume_tone_selector_unit_defines.svh"

module bpvt_checker
    import bpvt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result
    `BPVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Never mute and unmute together
    `BPVT_ASSERT_NOW(a_mute_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[22] && m_axis_tdata[23]))

    // Mute leaves the volume at the bottom of the table
    `BPVT_ASSERT_NOW(a_mute_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[22], m_axis_tdata[9:8] == 2'd0 && m_axis_tdata[7:0] == 8'd0 && !m_axis_tdata[24])

    // Tone steps only in tone mode and never mute
    `BPVT_ASSERT_NOW(a_tone_mode, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[21], m_axis_tdata[20] && !m_axis_tdata[22])

endmodule

bind button_press_volume_tone_selector_unit bpvt_checker u_bpvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb.sv */
// Self-checking testbench for the button press volume and tone selector
module tb;
    import bpvt_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PCT       = 25;
    localparam int HOLD_OFF_LEN   = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 400000;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_LONG_PRESS + CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_UNUSED  = '1;

    // Codec volume and tone period by index
    localparam logic [7:0] VOLUME_BY_STEP [4] = '{8'd0, 8'd128, 8'd192, 8'd255};
    localparam logic [7:0] PERIOD_BY_STEP [4] = '{8'd192, 8'd96, 8'd48, 8'd24};

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: [0] tick, [1] pressed, [7:2] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: [7:0] volume_level, [9:8] volume_step, [11:10] tone_step,
    // [19:12] samples_per_period, [20] tone_mode_led, [21] tone_changed,
    // [22] mute_on, [23] mute_off, [24] volume_write, [31:25] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [TICKS_W-1:0]     i_cfg_data    = '0;

    // Predictor copy of the selector state and its registers
    logic [TICKS_W-1:0] debounce_len = 16'd50;
    logic [TICKS_W-1:0] hold_len     = 16'd1000;
    logic [1:0]         press_state  = PH_IDLE;
    logic [TICKS_W-1:0] delay_left   = '0;
    logic               tone_sel     = 1'b0;
    logic [1:0]         vol_idx      = 2'd2;
    logic [1:0]         tone_idx     = 2'd2;

    t_result due_selections [$];
    int      polls_sent  = 0;
    int      error_count = 0;
    int      cycle_count = 0;
    bit      no_idle     = 1'b0;
    int      stall_token = 0;

    button_press_volume_tone_selector_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Abort a run that stops making progress
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Advance the predicted selector by one poll and queue its outcome
    task automatic advance_selector(input bit tick, input bit pressed);
        t_result    r;
        logic [1:0] old_vol;
        r = '0;
        if (tick && delay_left != 0)
            delay_left--;
        case (press_state)
            PH_IDLE: begin
                if (delay_left == 0 && pressed) begin
                    delay_left  = debounce_len;
                    press_state = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (delay_left == 0 && pressed) begin
                    delay_left  = hold_len;
                    press_state = PH_HELD;
                end
            end
            PH_HELD: begin
                if (delay_left != 0 && !pressed) begin
                    // Short press: step tone or volume depending on mode
                    if (tone_sel) begin
                        tone_idx       = tone_idx + 2'd1;
                        r.tone_changed = 1'b1;
                        if (VOLUME_BY_STEP[vol_idx] == 0) begin
                            vol_idx        = vol_idx + 2'd1;
                            r.volume_write = 1'b1;
                            r.mute_off     = 1'b1;
                        end
                    end else begin
                        old_vol = vol_idx;
                        vol_idx = vol_idx + 2'd1;
                        if (VOLUME_BY_STEP[vol_idx] == 0) begin
                            r.mute_on = 1'b1;
                        end else begin
                            r.volume_write = 1'b1;
                            r.mute_off     = (VOLUME_BY_STEP[old_vol] == 0);
                        end
                    end
                    delay_left  = debounce_len;
                    press_state = PH_IDLE;
                end else if (delay_left == 0 && pressed) begin
                    // Long press: swap between volume and tone mode
                    tone_sel    = ~tone_sel;
                    press_state = PH_WAIT_RELEASE;
                end
            end
            default: begin
                if (!pressed) begin
                    delay_left  = debounce_len;
                    press_state = PH_IDLE;
                end
            end
        endcase
        r.volume_level       = VOLUME_BY_STEP[vol_idx];
        r.volume_step        = vol_idx;
        r.tone_step          = tone_idx;
        r.samples_per_period = PERIOD_BY_STEP[tone_idx];
        r.tone_mode_led      = tone_sel;
        due_selections.push_back(r);
    endtask

    // Offer one poll request, idling at random first, and hold until taken
    task automatic send_poll(input bit tick, input bit pressed);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, pressed, tick};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_selector(tick, pressed);
        polls_sent++;
    endtask

    // Register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [TICKS_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DEBOUNCE)
            debounce_len = val;
        else if (idx == CFG_LONG_PRESS)
            hold_len = val;
    endtask

    task automatic set_ticks(input logic [TICKS_W-1:0] deb, input logic [TICKS_W-1:0] lng);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, lng);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every outstanding result has been taken
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due_selections.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Quick press and release; the release can carry a tick
    task automatic tap(input bit tick_on_release);
        send_poll(1'b0, 1'b1);
        send_poll(1'b0, 1'b1);
        send_poll(tick_on_release, 1'b0);
    endtask

    // Button episodes: released gap, a hold with the odd bounce, release; plus noise
    task automatic run_press_episodes(input int n_polls, input int tick_pct,
                                      input int max_gap, input int max_hold);
        int target;
        int hold;
        target = polls_sent + n_polls;
        while (polls_sent < target) begin
            if ($urandom_range(99) < 85) begin
                repeat ($urandom_range(max_gap))
                    send_poll($urandom_range(99) < tick_pct, 1'b0);
                hold = $urandom_range(max_hold, 1);
                repeat (hold)
                    send_poll($urandom_range(99) < tick_pct, $urandom_range(99) >= 8);
                send_poll($urandom_range(99) < tick_pct, 1'b0);
            end else begin
                repeat ($urandom_range(6, 1))
                    send_poll(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    // One configuration phase: idle the block, rewrite the registers, run episodes
    task automatic run_phase(input logic [TICKS_W-1:0] deb, input logic [TICKS_W-1:0] lng,
                             input int n_polls, input int tick_pct,
                             input int max_gap, input int max_hold);
        settle();
        write_reg(CFG_INDEX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                  TICKS_W'($urandom));
        set_ticks(deb, lng);
        run_press_episodes(n_polls, tick_pct, max_gap, max_hold);
    endtask

    // Exercise the register values left by reset on exact tick boundaries
    task automatic test_reset_registers();
        send_poll(1'b1, 1'b1);
        repeat (49) send_poll(1'b1, 1'b1);
        // debounce runs out on a release, so the phase must hold
        send_poll(1'b1, 1'b0);
        send_poll(1'b0, 1'b1);
        repeat (3) send_poll(1'b1, 1'b1);
        send_poll(1'b1, 1'b0);
        repeat (50) send_poll(1'b1, 1'b0);
    endtask

    // Walk through the named corner cases with zero debounce and one hold tick
    task automatic test_directed();
        settle();
        write_reg(CFG_LAST_UNUSED, '1);
        set_ticks('0, 16'd1);
        // volume wraps to mute
        tap(1'b0);
        // long press into tone mode
        send_poll(1'b0, 1'b1);
        send_poll(1'b0, 1'b1);
        send_poll(1'b1, 1'b1);
        send_poll(1'b0, 1'b0);
        // tone step lifts muted volume, then tone wraps
        tap(1'b0);
        tap(1'b0);
        // release while debouncing holds the phase
        send_poll(1'b0, 1'b1);
        send_poll(1'b0, 1'b0);
        send_poll(1'b0, 1'b1);
        send_poll(1'b0, 1'b0);
        // hold time runs out on a release, next press counts as long
        send_poll(1'b0, 1'b1);
        send_poll(1'b0, 1'b1);
        send_poll(1'b1, 1'b0);
        send_poll(1'b0, 1'b1);
        send_poll(1'b0, 1'b0);
    endtask

    task automatic test_random_settings();
        run_phase('0, '0, 150, 50, 3, 6);
        run_phase(16'd1, 16'd3, 300, 60, 4, 10);
        // long stretch with both sides always ready
        no_idle = 1'b1;
        run_phase(16'd3, 16'd8, 300, 70, 6, 20);
        no_idle = 1'b0;
        run_phase(16'd2, 16'd1, 200, 50, 4, 8);
        repeat (3)
            run_phase(TICKS_W'($urandom_range(4)), TICKS_W'($urandom_range(12)), 120, 60, 5, 16);
    endtask

    task automatic test_extreme_settings();
        run_phase('1, '1, 40, 100, 3, 30);
        run_phase('0, '1, 40, 100, 3, 30);
        run_phase('1, '0, 40, 100, 3, 30);
    endtask

    // Receiver holds off while the sender keeps offering, then drain fully
    task automatic test_backpressure();
        settle();
        set_ticks(16'd1, 16'd2);
        no_idle = 1'b1;
        stall_token++;
        run_press_episodes(150, 60, 3, 8);
        no_idle = 1'b0;
        settle();
    endtask

    // Drive result ready: random idling, or a counted hold-off on request
    always @(posedge i_clk) begin : drive_result_ready
        static int stall_seen = 0;
        static int stall_left = 0;
        if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = HOLD_OFF_LEN;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (due_selections.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = due_selections.pop_front();
                check_field("volume_level", 32'(want.volume_level), 32'(got.volume_level));
                check_field("volume_step", 32'(want.volume_step), 32'(got.volume_step));
                check_field("tone_step", 32'(want.tone_step), 32'(got.tone_step));
                check_field("samples_per_period", 32'(want.samples_per_period),
                            32'(got.samples_per_period));
                check_field("tone_mode_led", 32'(want.tone_mode_led),
                            32'(got.tone_mode_led));
                check_field("tone_changed", 32'(want.tone_changed), 32'(got.tone_changed));
                check_field("mute_on", 32'(want.mute_on), 32'(got.mute_on));
                check_field("mute_off", 32'(want.mute_off), 32'(got.mute_off));
                check_field("volume_write", 32'(want.volume_write), 32'(got.volume_write));
                check_field("tdata padding", 0,
                            32'(m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)]));
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_registers();
        test_directed();
        test_random_settings();
        test_extreme_settings();
        test_backpressure();
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_selections.size() != 0) begin
            $display("%0t: %0d results never arrived, expected 0 left, actual %0d",
                     $time, due_selections.size(), due_selections.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/bpvt_pkg.sv
sv/bpvt_cfg_regs.sv
sv/bpvt_press_fsm.sv
sv/button_press_volume_tone_selector_unit.sv
sv/bpvt_checker.sv
sim/tb.sv
